### rtl/audio_frame_header_parser_unit_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef AUDIO_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH
`define AUDIO_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define AFHP_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);
// Implication with the right side checked in the cycle after the left side.
`define AFHP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);
`endif

### rtl/afhp_pkg.sv
package afhp_pkg;

	localparam int unsigned BufferBytes = 262144;

	typedef enum logic [2:0] {
		CODEC_NONE = 3'd0,
		CODEC_MPG  = 3'd1,
		CODEC_AC3  = 3'd2,
		CODEC_EAC3 = 3'd3,
		CODEC_ADTS = 3'd4
	} codec_t;

	// Result item as carried between stages.
	typedef struct packed {
		logic [18:0] frame_size;
		logic [16:0] sample_rate;
		logic [3:0]  channel_count;
		logic [2:0]  codec;
	} result_t;

	// MPEG audio bitrate in kbit/s by lsf, layer - 1 and index.
	function automatic logic [8:0] mpa_kbps(input logic lsf, input logic [1:0] lay,
			input logic [3:0] idx);
		logic [8:0] v;
		v = 9'd0;
		if (!lsf) begin
			unique case (lay)
				2'd0: begin
					v = (idx == 4'd15) ? 9'd0 : 9'({5'd0, idx} * 9'd32);
				end
				2'd1: begin
					unique case (idx)
						4'd1: v = 9'd32;  4'd2: v = 9'd48;  4'd3: v = 9'd56;
						4'd4: v = 9'd64;  4'd5: v = 9'd80;  4'd6: v = 9'd96;
						4'd7: v = 9'd112; 4'd8: v = 9'd128; 4'd9: v = 9'd160;
						4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
						4'd13: v = 9'd320; 4'd14: v = 9'd384;
						default: v = 9'd0;
					endcase
				end
				default: begin
					unique case (idx)
						4'd1: v = 9'd32;  4'd2: v = 9'd40;  4'd3: v = 9'd48;
						4'd4: v = 9'd56;  4'd5: v = 9'd64;  4'd6: v = 9'd80;
						4'd7: v = 9'd96;  4'd8: v = 9'd112; 4'd9: v = 9'd128;
						4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
						4'd13: v = 9'd256; 4'd14: v = 9'd320;
						default: v = 9'd0;
					endcase
				end
			endcase
		end else begin
			if (lay == 2'd0) begin
				unique case (idx)
					4'd1: v = 9'd32;  4'd2: v = 9'd48;  4'd3: v = 9'd56;
					4'd4: v = 9'd64;  4'd5: v = 9'd80;  4'd6: v = 9'd96;
					4'd7: v = 9'd112; 4'd8: v = 9'd128; 4'd9: v = 9'd144;
					4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
					4'd13: v = 9'd224; 4'd14: v = 9'd256;
					default: v = 9'd0;
				endcase
			end else begin
				unique case (idx)
					4'd1: v = 9'd8;   4'd2: v = 9'd16;  4'd3: v = 9'd24;
					4'd4: v = 9'd32;  4'd5: v = 9'd40;  4'd6: v = 9'd48;
					4'd7: v = 9'd56;  4'd8: v = 9'd64;  4'd9: v = 9'd80;
					4'd10: v = 9'd96; 4'd11: v = 9'd112; 4'd12: v = 9'd128;
					4'd13: v = 9'd144; 4'd14: v = 9'd160;
					default: v = 9'd0;
				endcase
			end
		end
		return v;
	endfunction

	// AC-3 frame length in 16-bit words by size code and rate code.
	function automatic logic [10:0] dd_words(input logic [5:0] code, input logic [1:0] fs);
		logic [10:0] base;
		logic [10:0] w441;
		base = 11'd0;
		w441 = 11'd0;
		unique case (code[5:1])
			5'd0: begin base = 11'd64; w441 = 11'd69; end
			5'd1: begin base = 11'd80; w441 = 11'd87; end
			5'd2: begin base = 11'd96; w441 = 11'd104; end
			5'd3: begin base = 11'd112; w441 = 11'd121; end
			5'd4: begin base = 11'd128; w441 = 11'd139; end
			5'd5: begin base = 11'd160; w441 = 11'd174; end
			5'd6: begin base = 11'd192; w441 = 11'd208; end
			5'd7: begin base = 11'd224; w441 = 11'd243; end
			5'd8: begin base = 11'd256; w441 = 11'd278; end
			5'd9: begin base = 11'd320; w441 = 11'd348; end
			5'd10: begin base = 11'd384; w441 = 11'd417; end
			5'd11: begin base = 11'd448; w441 = 11'd487; end
			5'd12: begin base = 11'd512; w441 = 11'd557; end
			5'd13: begin base = 11'd640; w441 = 11'd696; end
			5'd14: begin base = 11'd768; w441 = 11'd835; end
			5'd15: begin base = 11'd896; w441 = 11'd975; end
			5'd16: begin base = 11'd1024; w441 = 11'd1114; end
			5'd17: begin base = 11'd1152; w441 = 11'd1253; end
			5'd18: begin base = 11'd1280; w441 = 11'd1393; end
			default: begin base = 11'd0; w441 = 11'd0; end
		endcase
		unique case (fs)
			2'd0: return base;
			2'd1: return 11'(w441 + {10'd0, code[0]});
			default: return 11'(base + (base >> 1));
		endcase
	endfunction

	function automatic logic [2:0] dd_chan(input logic [2:0] acmod);
		unique case (acmod)
			3'd0: return 3'd2;
			3'd1: return 3'd1;
			3'd2: return 3'd2;
			3'd3, 3'd4: return 3'd3;
			3'd5, 3'd6: return 3'd4;
			default: return 3'd5;
		endcase
	endfunction

	function automatic logic [16:0] dd_rate(input logic [1:0] fs);
		unique case (fs)
			2'd0: return 17'd48000;
			2'd1: return 17'd44100;
			2'd2: return 17'd32000;
			default: return 17'd0;
		endcase
	endfunction

	function automatic logic [16:0] aac_rate(input logic [3:0] idx);
		unique case (idx)
			4'd0: return 17'd96000;  4'd1: return 17'd88200;
			4'd2: return 17'd64000;  4'd3: return 17'd48000;
			4'd4: return 17'd44100;  4'd5: return 17'd32000;
			4'd6: return 17'd24000;  4'd7: return 17'd22050;
			4'd8: return 17'd16000;  4'd9: return 17'd12000;
			4'd10: return 17'd11025; 4'd11: return 17'd8000;
			4'd12: return 17'd7350;
			default: return 17'd0;
		endcase
	endfunction

	// MPEG sample rate by index, already divided for lsf streams.
	function automatic logic [16:0] mpa_rate(input logic [1:0] idx, input logic [1:0] sh);
		logic [16:0] r;
		unique case (idx)
			2'd0: r = 17'd44100;
			2'd1: r = 17'd48000;
			2'd2: r = 17'd32000;
			default: r = 17'd0;
		endcase
		return r >> sh;
	endfunction

endpackage

### rtl/audio_frame_header_parser_unit.sv
// Audio frame header parser.
// Slave channel s_axis_*: one transfer per candidate position carrying seven
// header bytes and the count of bytes available there. Master channel
// m_axis_*: one transfer per input with codec, channel count (LFE included),
// sample rate in hertz and frame length in bytes (0 when incomplete).
// Sync priority is MPEG audio, then AC-3 / E-AC-3, then ADTS.
// Throughput is one item per cycle while the receiver does not stall.
// Stage 1 matches sync and looks up tables, stage 2
// forms the MPEG numerator, stages 3 to 19 divide by the sample rate (the
// first of them takes the top eleven numerator bits at once, the others one
// quotient bit each), and the final stage applies padding and the limit.
// The divider is the longest part of the pipeline and sets the latency.
// When the receiver stalls with a result waiting, every stage holds and
// s_axis_tready is low; nothing is lost or repeated.
// Reset (arst_n low) empties all stages; payload registers are not cleared.
`include "audio_frame_header_parser_unit_defines.svh"

module audio_frame_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// byte0[7:0], byte1[15:8], ... byte6[55:48], avail[74:56], zero fill
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// codec[2:0], channel_count[6:3], sample_rate[23:7], frame_size[42:24], zero fill
	output logic [47:0] m_axis_tdata
);
	import afhp_pkg::*;

	localparam int unsigned NumW = 27;
	localparam int unsigned DivStages = 17;

	// One stage's payload for the divide.
	typedef struct packed {
		result_t     res;
		logic        is_mpa;
		logic [1:0]  mode;
		logic        pad;
		logic [18:0] avail;
		logic [NumW-1:0] rem;
		logic [NumW-1:0] quo;
	} div_t;

	logic        v_s1;
	logic        stall;
	logic [7:0]  b [7];
	logic [18:0] n_in;

	// Stage 1 results.
	result_t     res_s1;
	logic        is_mpa_s1;
	logic [1:0]  mode_s1;
	logic        pad_s1;
	logic [8:0]  kb_s1;
	logic [18:0] avail_s1;

	logic [DivStages:0] dv_q;
	div_t        dd_q [DivStages+1];
	logic        out_v_q;
	result_t     out_q;

	assign stall = out_v_q && !m_axis_tready;
	assign s_axis_tready = !stall;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'd0, out_q.frame_size, out_q.sample_rate,
		out_q.channel_count, out_q.codec};

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			b[i] = s_axis_tdata[8*i +: 8];
		end
		n_in = (s_axis_tdata[74:56] > 19'(BufferBytes)) ? 19'(BufferBytes)
			: s_axis_tdata[74:56];
	end

	// Stage 1: sync match and table lookups.
	always_ff @(posedge clk) begin
		logic sm, sd, sa, lsf, eac;
		logic [1:0] sh, lay;
		logic [16:0] r;
		logic [2:0] acm, conf;
		logic lfe;
		logic [5:0] code;
		logic [8:0] kb;
		result_t res;
		logic mpa;
		logic [1:0] md;
		if (!stall) begin
			sm = b[0] == 8'hFF && (b[1] & 8'hE0) == 8'hE0 && (b[1] & 8'h18) != 8'h08
				&& (b[1] & 8'h06) != 8'h00 && (b[2] & 8'hF0) != 8'hF0
				&& (b[2] & 8'h0C) != 8'h0C;
			sd = b[0] == 8'h0B && b[1] == 8'h77;
			sa = b[0] == 8'hFF && (b[1] & 8'hF6) == 8'hF0 && (b[2] & 8'h3C) != 8'h3C;
			lsf = !b[1][3];
			sh = lsf ? (b[1][4] ? 2'd1 : 2'd2) : 2'd0;
			lay = 2'(3'd3 - {1'b0, b[1][2:1]});
			r = mpa_rate(b[2][3:2], sh);
			eac = b[5][7:3] > 5'd10;
			kb = mpa_kbps(lsf, lay, b[2][7:4]);
			res = '0;
			mpa = 1'b0;
			md = 2'd0;
			if (n_in < 19'd3) begin
				res = '0;
			end else if (sm) begin
				res.codec = CODEC_MPG;
				res.frame_size = n_in;
				if (n_in >= 19'd4) begin
					res.channel_count = (b[3][7:6] == 2'd3) ? 4'd1 : 4'd2;
					res.sample_rate = r;
					mpa = 1'b1;
					md = (lay == 2'd0) ? 2'd0 : ((lay == 2'd2 && lsf) ? 2'd1 : 2'd2);
					if (r == 17'd0 || kb == 9'd0) begin
						res = '0;
						mpa = 1'b0;
					end
				end
			end else if (sd) begin
				res.codec = (n_in > 19'd5 && eac) ? CODEC_EAC3 : CODEC_AC3;
				res.frame_size = n_in;
				if (n_in >= 19'd7) begin
					if (eac) begin
						acm = b[4][3:1];
						lfe = b[4][0];
						res.sample_rate = dd_rate(b[4][7:6]);
						if (b[4][7:6] == 2'd3) begin
							res.sample_rate = dd_rate(b[4][5:4]) >> 1;
						end
						res.frame_size = 19'({8'd0, b[2][2:0], b[3]} + 19'd1) << 1;
						res.channel_count = 4'(dd_chan(acm)) + 4'(lfe);
						if (b[4][7:6] == 2'd3 && b[4][5:4] == 2'd3) begin
							res = '0;
						end
					end else begin
						code = b[4][5:0];
						acm = b[6][7:5];
						// The LFE flag sits after the optional mix level fields.
						if (acm == 3'd1 || acm == 3'd0) lfe = b[6][4];
						else if (acm == 3'd5 || acm == 3'd7) lfe = b[6][0];
						else lfe = b[6][2];
						res.sample_rate = dd_rate(b[4][7:6]);
						res.frame_size = 19'({dd_words(code, b[4][7:6]), 1'b0});
						res.channel_count = 4'(dd_chan(acm)) + 4'(lfe);
						if (b[4][7:6] == 2'd3 || code > 6'd37) begin
							res = '0;
						end
					end
				end
			end else if (sa) begin
				res.codec = CODEC_ADTS;
				res.frame_size = n_in;
				if (n_in >= 19'd6) begin
					conf = {b[2][0], b[3][7:6]};
					res.sample_rate = aac_rate(b[2][5:2]);
					res.frame_size = {6'd0, b[3][1:0], b[4], b[5][7:5]};
					res.channel_count = (conf == 3'd7) ? 4'd8 : 4'(conf);
					if (aac_rate(b[2][5:2]) == 17'd0 || conf == 3'd0) begin
						res = '0;
					end
				end
			end
			res_s1 <= res;
			is_mpa_s1 <= mpa;
			mode_s1 <= md;
			pad_s1 <= b[2][1];
			kb_s1 <= kb;
			avail_s1 <= n_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			dv_q <= '0;
			out_v_q <= 1'b0;
		end else if (!stall) begin
			v_s1 <= s_axis_tvalid;
			dv_q <= {dv_q[DivStages-1:0], v_s1};
			out_v_q <= dv_q[DivStages];
		end
	end

	// Stage 2: numerator = constant times bitrate, one multiply.
	always_ff @(posedge clk) begin
		logic [17:0] k;
		div_t d;
		if (!stall) begin
			unique case (mode_s1)
				2'd0: k = 18'd12000;
				2'd1: k = 18'd72000;
				default: k = 18'd144000;
			endcase
			d.res = res_s1;
			d.is_mpa = is_mpa_s1;
			d.mode = mode_s1;
			d.pad = pad_s1;
			d.avail = avail_s1;
			d.rem = '0;
			d.quo = NumW'(k) * NumW'(kb_s1);
			dd_q[0] <= d;
		end
	end

	// Restoring divide: each stage resolves one quotient bit (numerator shifts
	// in from the top of quo while quotient bits fill the bottom).
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		always_ff @(posedge clk) begin
			logic [NumW:0] t;
			logic [NumW-1:0] q;
			div_t d;
			if (!stall) begin
				d = dd_q[g];
				if (g == 0) begin
					// The top eleven numerator bits stay below any sample rate.
					t = {1'b0, d.rem[NumW-12:0], d.quo[NumW-1 -: 11]};
					q = d.quo << 11;
				end else begin
					t = {d.rem, d.quo[NumW-1]};
					q = d.quo << 1;
				end
				if (t >= {11'd0, d.res.sample_rate}) begin
					d.rem = NumW'(t - {11'd0, d.res.sample_rate});
					d.quo = q | NumW'(1);
				end else begin
					d.rem = NumW'(t);
					d.quo = q;
				end
				dd_q[g+1] <= d;
			end
		end
	end

	// Final stage: padding, layer I scaling and the completeness limit.
	always_ff @(posedge clk) begin
		logic [18:0] len;
		logic [NumW-1:0] qv;
		result_t o;
		if (!stall) begin
			o = dd_q[DivStages].res;
			len = o.frame_size;
			if (dd_q[DivStages].is_mpa) begin
				qv = dd_q[DivStages].quo + NumW'(dd_q[DivStages].pad);
				len = (dd_q[DivStages].mode == 2'd0) ? 19'(qv << 2) : 19'(qv);
			end
			o.frame_size = (len > dd_q[DivStages].avail) ? 19'd0 : len;
			out_q <= o;
		end
	end

	`AFHP_ASSERT_IMP(a_out_codec, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4, "codec out of range")
	`AFHP_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`AFHP_ASSERT_IMP(a_none_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[2:0] == 3'd0, m_axis_tdata[42:3] == 40'd0, "invalid result not zeroed")

endmodule

### tb/audio_frame_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module audio_frame_header_parser_unit_tb;
	import afhp_pkg::*;

	// Decoded header fields of one expected or observed result.
	typedef struct {
		logic [2:0]  codec;
		logic [3:0]  channel_count;
		logic [16:0] sample_rate;
		logic [18:0] frame_size;
	} header_info_t;

	// Header decoder that mirrors the block, plus the queue of pending results.
	class header_scoreboard;
		header_info_t pending[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned codec_seen[5];

		function int unsigned mpeg_kbps(int unsigned lsf, int unsigned layer,
				int unsigned idx);
			int unsigned t1[16];
			int unsigned t2[16];
			int unsigned t3[16];
			int unsigned l1[16];
			int unsigned l2[16];
			t1 = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
			t2 = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
			t3 = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
			l1 = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
			l2 = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
			if (lsf == 0) begin
				if (layer == 1) return t1[idx];
				if (layer == 2) return t2[idx];
				return t3[idx];
			end
			if (layer == 1) return l1[idx];
			return l2[idx];
		endfunction

		function header_info_t decode(logic [7:0] b[7], logic [18:0] avail_in);
			header_info_t r;
			int unsigned n, len, ch, rate, lsf, shift, layer, pad, kb, fs, fs2;
			int unsigned acmod, lfe, code, pos, conf;
			int unsigned mrate[4];
			int unsigned arate[16];
			int unsigned drate[4];
			int unsigned dchan[8];
			int unsigned achan[8];
			int unsigned w48[19];
			int unsigned w441[19];
			bit ok;
			logic [2:0] cd;
			mrate = '{44100, 48000, 32000, 0};
			arate = '{96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050,
				16000, 12000, 11025, 8000, 7350, 0, 0, 0};
			drate = '{48000, 44100, 32000, 0};
			dchan = '{2, 1, 2, 3, 3, 4, 4, 5};
			achan = '{0, 1, 2, 3, 4, 5, 6, 8};
			w48 = '{64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640,
				768, 896, 1024, 1152, 1280};
			w441 = '{69, 87, 104, 121, 139, 174, 208, 243, 278, 348, 417, 487, 557, 696,
				835, 975, 1114, 1253, 1393};
			n = avail_in;
			if (n > BufferBytes) n = BufferBytes;
			cd = CODEC_NONE;
			len = 0;
			ch = 0;
			rate = 0;
			ok = 0;
			if (n >= 3) begin
				// MPEG audio sync has priority.
				if (b[0] == 8'hFF && (b[1] & 8'hE0) == 8'hE0 && (b[1] & 8'h18) != 8'h08
						&& (b[1] & 8'h06) != 0 && (b[2] & 8'hF0) != 8'hF0
						&& (b[2] & 8'h0C) != 8'h0C) begin
					len = n;
					ok = 1;
					if (n >= 4) begin
						lsf = b[1][3] ? 0 : 1;
						shift = lsf ? (b[1][4] ? 1 : 2) : 0;
						layer = 4 - b[1][2:1];
						pad = b[2][1];
						ch = (b[3][7:6] == 2'd3) ? 1 : 2;
						rate = mrate[b[2][3:2]] >> shift;
						kb = mpeg_kbps(lsf, layer, b[2][7:4]);
						if (rate == 0 || kb == 0) ok = 0;
						else if (layer == 1) len = ((12000 * kb) / rate + pad) * 4;
						else if (layer == 3 && lsf) len = (72000 * kb) / rate + pad;
						else len = (144000 * kb) / rate + pad;
					end
					if (ok) cd = CODEC_MPG;
				end else if (b[0] == 8'h0B && b[1] == 8'h77) begin
					len = n;
					ok = 1;
					if (n >= 7) begin
						fs = b[4][7:6];
						rate = drate[fs];
						if (b[5][7:3] > 10) begin
							if (fs == 3) begin
								fs2 = b[4][5:4];
								if (fs2 == 3) ok = 0;
								else rate = drate[fs2] / 2;
							end
							acmod = b[4][3:1];
							lfe = b[4][0];
							len = ((b[2][2:0] << 8) + b[3] + 1) * 2;
						end else begin
							code = b[4][5:0];
							pos = 51;
							if (fs == 3 || code > 37) ok = 0;
							acmod = b[6][7:5];
							if (acmod[0] && acmod != 1) pos += 2;
							if (acmod[2]) pos += 2;
							if (acmod == 2) pos += 2;
							lfe = b[6][7 - (pos % 8)];
							if (ok) begin
								if (fs == 0) len = w48[code / 2] * 2;
								else if (fs == 1) len = (w441[code / 2] + code % 2) * 2;
								else len = w48[code / 2] * 3;
							end
						end
						ch = dchan[acmod] + lfe;
					end
					if (ok) cd = (n > 5 && b[5][7:3] > 10) ? CODEC_EAC3 : CODEC_AC3;
				end else if (b[0] == 8'hFF && (b[1] & 8'hF6) == 8'hF0
						&& (b[2] & 8'h3C) != 8'h3C) begin
					len = n;
					ok = 1;
					if (n >= 6) begin
						rate = arate[b[2][5:2]];
						len = (b[3][1:0] << 11) | (b[4] << 3) | b[5][7:5];
						conf = {b[2][0], b[3][7:6]};
						ch = achan[conf];
						ok = (rate != 0 && ch != 0);
					end
					if (ok) cd = CODEC_ADTS;
				end
			end
			if (cd == CODEC_NONE) begin
				len = 0;
				ch = 0;
				rate = 0;
			end else if (len > n) begin
				len = 0;
			end
			r.codec = cd;
			r.channel_count = 4'(ch);
			r.sample_rate = 17'(rate);
			r.frame_size = 19'(len);
			return r;
		endfunction

		function void note_header(logic [79:0] data);
			logic [7:0] b[7];
			for (int i = 0; i < 7; i++) b[i] = data[8 * i +: 8];
			pending.push_back(decode(b, data[74:56]));
		endfunction

		function void check_result(logic [47:0] data);
			header_info_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no pending header: %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.codec < 5) codec_seen[e.codec]++;
			if (data[2:0] !== e.codec) begin
				$error("codec: expected %0d, got %0d", e.codec, data[2:0]);
				errors++;
			end
			if (data[6:3] !== e.channel_count) begin
				$error("channel_count: expected %0d, got %0d", e.channel_count, data[6:3]);
				errors++;
			end
			if (data[23:7] !== e.sample_rate) begin
				$error("sample_rate: expected %0d, got %0d", e.sample_rate, data[23:7]);
				errors++;
			end
			if (data[42:24] !== e.frame_size) begin
				$error("frame_size: expected %0d, got %0d", e.frame_size, data[42:24]);
				errors++;
			end
			if (data[47:43] !== 5'd0) begin
				$error("fill bits: expected 0, got %h", data[47:43]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// byte0 .. byte6, avail, zero fill
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// codec, channel_count, sample_rate, frame_size, zero fill
	logic [47:0] m_axis_tdata;

	header_scoreboard board;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned cycles;
	bit stimulus_done;

	audio_frame_header_parser_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: stall at random and check each result transfer.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Send one header transfer, with a random idle gap first. The valid line
	// stays high after the transfer so that back-to-back transfers have no gap.
	task automatic send_header(logic [7:0] b[7], logic [18:0] avail_in);
		logic [79:0] d;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		d = '0;
		for (int i = 0; i < 7; i++) d[8 * i +: 8] = b[i];
		d[74:56] = avail_in;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		board.note_header(d);
		@(negedge clk);
	endtask

	function automatic logic [18:0] pick_avail();
		case ($urandom_range(9))
			0: return 19'($urandom_range(7));
			1: return 19'($urandom_range(19'h7FFFF));
			2: return 19'(BufferBytes + $urandom_range(1));
			3: return 19'($urandom_range(20000));
			default: return 19'($urandom_range(4096));
		endcase
	endfunction

	// Random header: mostly well-formed sync patterns with random content.
	task automatic random_header();
		logic [7:0] b[7];
		for (int i = 0; i < 7; i++) b[i] = 8'($urandom_range(255));
		case ($urandom_range(9))
			0, 1, 2: begin
				b[0] = 8'hFF;
				b[1] = 8'hE0 | b[1];
			end
			3, 4: begin
				b[0] = 8'h0B;
				b[1] = 8'h77;
				if ($urandom_range(1)) b[4][5:0] = 6'($urandom_range(37));
			end
			5, 6: begin
				b[0] = 8'hFF;
				b[1] = 8'hF0 | (b[1] & 8'h09);
			end
			7: b[0] = 8'hFF;
			default: ;
		endcase
		send_header(b, pick_avail());
	endtask

	task automatic directed_headers();
		logic [7:0] b[7];
		// No sync, all zero and all ones, too few bytes.
		b = '{0, 0, 0, 0, 0, 0, 0};
		send_header(b, 0);
		b = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_header(b, 19'h7FFFF);
		b = '{8'hFF, 8'hFB, 8'h90, 8'h00, 0, 0, 0};
		send_header(b, 2);
		// MPEG-1 Layer III, short header, then full and incomplete.
		send_header(b, 3);
		send_header(b, 1000);
		send_header(b, 100);
		// MPEG-1 Layer I mono with padding, MPEG-2 Layer III, MPEG-2.5.
		b = '{8'hFF, 8'hFF, 8'hE2, 8'hC0, 0, 0, 0};
		send_header(b, 19'(BufferBytes));
		b = '{8'hFF, 8'hF3, 8'hE6, 8'h40, 0, 0, 0};
		send_header(b, 5000);
		b = '{8'hFF, 8'hE3, 8'h14, 8'h00, 0, 0, 0};
		send_header(b, 5000);
		// Zero bitrate index makes MPEG invalid.
		b = '{8'hFF, 8'hFB, 8'h00, 8'h00, 0, 0, 0};
		send_header(b, 5000);
		// AC-3: short, full with lfe, bad size code, E-AC-3 short, full and reserved rate.
		b = '{8'h0B, 8'h77, 8'h00, 8'h00, 8'h64, 8'h40, 8'hF1};
		send_header(b, 6);
		send_header(b, 4000);
		b = '{8'h0B, 8'h77, 8'h00, 8'h00, 8'h3F, 8'h40, 8'h00};
		send_header(b, 4000);
		b = '{8'h0B, 8'h77, 8'h07, 8'hFF, 8'hE5, 8'h80, 8'h00};
		send_header(b, 6);
		send_header(b, 19'(BufferBytes));
		b = '{8'h0B, 8'h77, 8'h01, 8'h00, 8'hFF, 8'h80, 8'h00};
		send_header(b, 4000);
		// ADTS: short, full 5.1, zero configuration, reserved rate.
		b = '{8'hFF, 8'hF1, 8'h4C, 8'h80, 8'h20, 8'h1F, 8'hFC};
		send_header(b, 5);
		b = '{8'hFF, 8'hF1, 8'h4D, 8'h80, 8'h20, 8'h1F, 8'hFC};
		send_header(b, 4000);
		b = '{8'hFF, 8'hF1, 8'h4C, 8'h00, 8'h20, 8'h1F, 8'hFC};
		send_header(b, 4000);
		b = '{8'hFF, 8'hF1, 8'h34, 8'h80, 8'h20, 8'h1F, 8'hFC};
		send_header(b, 4000);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		directed_headers();
		// Idle phases: none, sender gaps, receiver stalls, both.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 45 : (phase == 3) ? 12 : 0;
			stall_pct = (phase == 2) ? 45 : (phase == 3) ? 12 : 0;
			repeat (370) random_header();
		end
		s_axis_tvalid <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("checked %0d results: none %0d, mpeg %0d, ac3 %0d, eac3 %0d, adts %0d",
			board.checked, board.codec_seen[0], board.codec_seen[1],
			board.codec_seen[2], board.codec_seen[3], board.codec_seen[4]);
		if (board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
